FILE: src/cimu_pkg.sv
// shared types and constants for the can imu sample reassembler
// no dependencies; used by every module under src
package cimu_pkg;

  localparam int unsigned IdW     = 11;
  localparam int unsigned FrIdW   = 29;
  localparam int unsigned WordW   = 16;
  localparam int unsigned DlcW    = 4;
  localparam int unsigned PayW    = 64;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned QDepth  = 2;

  localparam logic [DlcW-1:0]  FrameLen = 4'd8;
  localparam logic [IdW-1:0]   AccelIdRst = 11'h350;
  localparam logic [IdW-1:0]   GyroIdRst  = 11'h351;
  localparam logic [IdW-1:0]   TempIdRst  = 11'h352;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] RegAccelId = 2'd0;
  localparam logic [1:0] RegGyroId  = 2'd1;
  localparam logic [1:0] RegTempId  = 2'd2;

  typedef enum logic [2:0] {
    PART_NONE  = 3'b000,
    PART_ACCEL = 3'b001,
    PART_RATE  = 3'b010,
    PART_TEMP  = 3'b100
  } part_e;

  localparam logic [2:0] PartAll = 3'b111;

  // classified frame as it sits in the queue
  typedef struct packed {
    part_e             part;
    logic [WordW-1:0]  number;
    logic [WordW-1:0]  w0;
    logic [WordW-1:0]  w1;
    logic [WordW-1:0]  w2;
  } entry_t;

  typedef struct packed {
    logic              accepted;
    logic              sample_ready;
    logic [WordW-1:0]  sample_number;
    logic [WordW-1:0]  accel_x;
    logic [WordW-1:0]  accel_y;
    logic [WordW-1:0]  accel_z;
    logic [WordW-1:0]  rate_x;
    logic [WordW-1:0]  rate_y;
    logic [WordW-1:0]  rate_z;
    logic [WordW-1:0]  temp_reading;
  } result_t;

endpackage

FILE: src/cimu_front.sv
// front end: configuration registers, apb port and frame classification
// depends on cimu_pkg
module cimu_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cimu_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  input  logic                        is_extended_i,
  input  logic                        is_remote_i,
  input  logic [cimu_pkg::DlcW-1:0]   length_code_i,
  input  logic [cimu_pkg::FrIdW-1:0]  frame_ident_i,
  input  logic [cimu_pkg::PayW-1:0]   payload_i,
  output cimu_pkg::entry_t            entry_o
);

  logic [cimu_pkg::IdW-1:0] accel_id_q, gyro_id_q, temp_id_q;
  logic                     wr_en;
  logic                     std_ok;

  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_id_q <= cimu_pkg::AccelIdRst;
      gyro_id_q  <= cimu_pkg::GyroIdRst;
      temp_id_q  <= cimu_pkg::TempIdRst;
    end else if (wr_en) begin
      case (paddr[3:2])
        cimu_pkg::RegAccelId: accel_id_q <= pwdata[cimu_pkg::IdW-1:0];
        cimu_pkg::RegGyroId:  gyro_id_q  <= pwdata[cimu_pkg::IdW-1:0];
        cimu_pkg::RegTempId:  temp_id_q  <= pwdata[cimu_pkg::IdW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cimu_pkg::RegAccelId: prdata = {21'd0, accel_id_q};
      cimu_pkg::RegGyroId:  prdata = {21'd0, gyro_id_q};
      cimu_pkg::RegTempId:  prdata = {21'd0, temp_id_q};
      default:              prdata = '0;
    endcase
  end

  assign std_ok = !is_extended_i && !is_remote_i && (length_code_i == cimu_pkg::FrameLen);

  // full-width compare: identifiers above 11 bits never match
  always_comb begin
    entry_o.part = cimu_pkg::PART_NONE;
    if (std_ok) begin
      if (frame_ident_i == {18'd0, accel_id_q}) begin
        entry_o.part = cimu_pkg::PART_ACCEL;
      end else if (frame_ident_i == {18'd0, gyro_id_q}) begin
        entry_o.part = cimu_pkg::PART_RATE;
      end else if (frame_ident_i == {18'd0, temp_id_q}) begin
        entry_o.part = cimu_pkg::PART_TEMP;
      end
    end
    entry_o.number = payload_i[15:0];
    entry_o.w0     = payload_i[31:16];
    entry_o.w1     = payload_i[47:32];
    entry_o.w2     = payload_i[63:48];
  end

endmodule

FILE: src/cimu_queue.sv
// small fifo between the classifier and the sample assembler
// depends on cimu_pkg
module cimu_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cimu_pkg::entry_t  data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output cimu_pkg::entry_t  data_o
);

  localparam int unsigned PtrW = $clog2(cimu_pkg::QDepth);

  cimu_pkg::entry_t mem_q [cimu_pkg::QDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    count_q;

  assign full_o  = (count_q == cimu_pkg::QDepth[PtrW:0]);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: src/cimu_back.sv
// back end: sample store, restart on new sample number, output register
// depends on cimu_pkg
module cimu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  cimu_pkg::entry_t  q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cimu_pkg::result_t out_o
);

  logic [cimu_pkg::WordW-1:0] number_q, number_d;
  logic [cimu_pkg::WordW-1:0] ax_q, ay_q, az_q, ax_d, ay_d, az_d;
  logic [cimu_pkg::WordW-1:0] rx_q, ry_q, rz_q, rx_d, ry_d, rz_d;
  logic [cimu_pkg::WordW-1:0] tp_q, tp_d;
  logic [2:0]                 parts_q, parts_d, merged;
  logic                       restart;
  logic                       valid_q;
  cimu_pkg::result_t          res_q, res_d;

  assign q_pop_o     = q_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  assign restart = (number_q != q_data_i.number) || (parts_q == '0);

  always_comb begin
    number_d = number_q;
    ax_d = ax_q; ay_d = ay_q; az_d = az_q;
    rx_d = rx_q; ry_d = ry_q; rz_d = rz_q;
    tp_d = tp_q;
    merged  = parts_q;
    parts_d = parts_q;
    res_d   = '0;
    if (q_data_i.part != cimu_pkg::PART_NONE) begin
      res_d.accepted = 1'b1;
      if (restart) begin
        number_d = q_data_i.number;
        merged   = '0;
      end
      case (q_data_i.part)
        cimu_pkg::PART_ACCEL: begin
          ax_d = q_data_i.w0; ay_d = q_data_i.w1; az_d = q_data_i.w2;
        end
        cimu_pkg::PART_RATE: begin
          rx_d = q_data_i.w0; ry_d = q_data_i.w1; rz_d = q_data_i.w2;
        end
        default: begin
          tp_d = q_data_i.w0;
        end
      endcase
      merged  = merged | q_data_i.part;
      parts_d = merged;
      if (merged == cimu_pkg::PartAll) begin
        // sample complete: present it and empty the store
        res_d.sample_ready  = 1'b1;
        res_d.sample_number = number_d;
        res_d.accel_x       = ax_d;
        res_d.accel_y       = ay_d;
        res_d.accel_z       = az_d;
        res_d.rate_x        = rx_d;
        res_d.rate_y        = ry_d;
        res_d.rate_z        = rz_d;
        res_d.temp_reading  = tp_d;
        parts_d             = '0;
        number_d            = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parts_q  <= '0;
      number_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      if (q_pop_o) begin
        parts_q  <= parts_d;
        number_q <= number_d;
        valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        valid_q  <= 1'b0;
      end
    end
  end

  // data words only matter once all three parts are in, so no reset
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ax_q  <= ax_d;
      ay_q  <= ay_d;
      az_q  <= az_d;
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      rz_q  <= rz_d;
      tp_q  <= tp_d;
      res_q <= res_d;
    end
  end

endmodule

FILE: src/can_imu_sample_reassembler_top.sv
// Rebuilds raw motion-sensor samples from received CAN frames. Every request
// on the slave stream yields exactly one result on the master stream, in
// order: accepted tells whether the frame matched one of the three configured
// identifiers, and sample_ready marks the result that closes a complete
// sample (all data fields are zero otherwise). One frame is taken every
// clock cycle while the queue is not full; a frame goes through the classifier
// queue and then the assembler's output register before its result can be
// taken. While the output is stalled, the two-entry queue keeps taking
// frames until both entries are filled. Identifier registers are at byte
// addresses 0, 4 and 8 and should be written only while no frame is in flight.
//
// depends on cimu_pkg, cimu_front, cimu_queue, cimu_back
module can_imu_sample_reassembler_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cimu_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  // [3:0] length_code, [32:4] frame_ident, [96:33] payload, [103:97] zero
  input  logic [103:0]                s_tdata_i,
  // [0] is_extended, [1] is_remote
  input  logic [1:0]                  s_tuser_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  // [15:0] sample_number, [31:16] accel_x, [47:32] accel_y, [63:48] accel_z,
  // [79:64] rate_x, [95:80] rate_y, [111:96] rate_z, [127:112] temp_reading
  output logic [127:0]                m_tdata_o,
  // [0] accepted, [1] sample_ready
  output logic [1:0]                  m_tuser_o
);

  cimu_pkg::entry_t  front_entry, q_entry;
  cimu_pkg::result_t result;
  logic              q_full, q_valid, q_pop, push;

  assign pready     = 1'b1;
  assign s_tready_o = !q_full;
  assign push       = s_tvalid_i && !q_full;

  cimu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .is_extended_i (s_tuser_i[0]),
    .is_remote_i   (s_tuser_i[1]),
    .length_code_i (s_tdata_i[3:0]),
    .frame_ident_i (s_tdata_i[32:4]),
    .payload_i     (s_tdata_i[96:33]),
    .entry_o       (front_entry)
  );

  cimu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_entry)
  );

  cimu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_o       (result)
  );

  assign m_tuser_o = {result.sample_ready, result.accepted};
  assign m_tdata_o = {result.temp_reading, result.rate_z, result.rate_y, result.rate_x,
                      result.accel_z, result.accel_y, result.accel_x, result.sample_number};

endmodule
